FILE: design/tspp_pkg.sv
// Package for the transport stream packet parser: record layout, codes,
// constants and small decode helpers. Depends on nothing.
`default_nettype none
package tspp_pkg;

  localparam int PID_BITS = 13;
  localparam int PID_SPACE = 8192;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [7:0] SYNC_BYTE = 8'h47;
  localparam logic [7:0] PKT_LAST = 8'd187;
  localparam logic [15:0] PACKET_LIMIT_RESET = 16'd5000;
  localparam logic [3:0] PES_LIMIT_RESET = 4'd8;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_PACKET_LIMIT = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PES_LIMIT = 1'd1;

  typedef enum logic [2:0] {
    KIND_HEADER = 3'd0,
    KIND_PAT    = 3'd1,
    KIND_PMT    = 3'd2,
    KIND_PES    = 3'd3,
    KIND_SYNC   = 3'd4
  } tspp_kind_t;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_PAT  = 2'd1,
    MODE_PMT  = 2'd2
  } tspp_mode_t;

  typedef struct packed {
    tspp_kind_t    kind;
    logic [12:0]   pid;
    logic          unit_start;
    logic [15:0]   pkt_count;
    logic [15:0]   index;
    logic [15:0]   id;
    logic [12:0]   linked;
    logic          has_pts;
    logic [32:0]   pts;
    logic          has_dts;
    logic [32:0]   dts;
  } tspp_rec_t;

  typedef struct packed {
    logic                rd_en;
    logic [PID_BITS-1:0] rd_addr;
    logic                wr_en;
    logic [PID_BITS-1:0] wr_addr;
  } tspp_pid_req_t;

  // True unless the stream id is one whose PES header has no optional extension.
  function automatic logic pes_has_ext(input logic [7:0] sid);
    return !(sid == 8'hBC || sid == 8'hBE || sid == 8'hBF || sid == 8'hF0 ||
             sid == 8'hF1 || sid == 8'hF2 || sid == 8'hF8 || sid == 8'hFF);
  endfunction

  // 33-bit timestamp from the last five bytes, marker bits dropped.
  function automatic logic [32:0] ts_from_window(input logic [39:0] w);
    return {w[35:33], w[31:24], w[23:17], w[15:8], w[7:1]};
  endfunction

endpackage
`default_nettype wire

FILE: design/tspp_if.sv
// Stream channel interfaces of the transport stream packet parser.
// Depends on nothing.
`default_nettype none
interface tspp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface tspp_rec_if;
  logic        valid;
  logic        ready;
  logic [2:0]  record_kind;
  logic [12:0] packet_pid;
  logic        unit_start;
  logic [15:0] pid_packet_count;
  logic [15:0] packet_index;
  logic [15:0] id_value;
  logic [12:0] linked_pid;
  logic        has_pts;
  logic [32:0] pts;
  logic        has_dts;
  logic [32:0] dts;
  modport source (output valid, output record_kind, output packet_pid, output unit_start,
                  output pid_packet_count, output packet_index, output id_value,
                  output linked_pid, output has_pts, output pts, output has_dts,
                  output dts, input ready);
  modport sink   (input valid, input record_kind, input packet_pid, input unit_start,
                  input pid_packet_count, input packet_index, input id_value,
                  input linked_pid, input has_pts, input pts, input has_dts,
                  input dts, output ready);
endinterface
`default_nettype wire

FILE: design/tspp_pidmem.sv
// Per-PID counter memory: packet count and PES count for every PID.
// Depends on tspp_pkg. Clears itself after reset, one entry a cycle.
`default_nettype none
module tspp_pidmem #(
  parameter int COUNT_BITS = 16
) (
  input  wire                            clk,
  input  wire                            rst,
  input  tspp_pkg::tspp_pid_req_t        req,
  input  wire  [COUNT_BITS+3:0]          wr_data,
  output logic [COUNT_BITS+3:0]          rd_data,
  output logic                           clearing
);

  logic [COUNT_BITS+3:0] mem [tspp_pkg::PID_SPACE];
  logic [tspp_pkg::PID_BITS-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: design/tspp_outq.sv
// Two-entry record queue between the parser and the output channel.
// Depends on tspp_pkg.
`default_nettype none
module tspp_outq (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push,
  input  tspp_pkg::tspp_rec_t   din,
  output logic                  space,
  output logic                  valid,
  input  wire                   ready,
  output tspp_pkg::tspp_rec_t   head
);

  tspp_pkg::tspp_rec_t q0, q1;
  logic [1:0] count;
  logic pop;

  assign pop   = valid && ready;
  assign valid = (count != 2'd0);
  assign space = (count != 2'd2);
  assign head  = q0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (count == 2'd0) q0 <= din;
      else q1 <= din;
    end else if (pop && !push) begin
      q0 <= q1;
    end else if (push && pop) begin
      if (count == 2'd1) begin
        q0 <= din;
      end else begin
        q0 <= q1;
        q1 <= din;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/tspp_core.sv
// Per-byte parser: packet header, PAT/PMT sections, PES headers, program
// table and configuration. Depends on tspp_pkg; counters live in tspp_pidmem.
`default_nettype none
module tspp_core #(
  parameter int PROGRAM_SLOTS = 16,
  parameter int COUNT_BITS    = 16
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_write,
  input  wire  [tspp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire  [tspp_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  wire                                   acc,
  input  wire  [7:0]                            data_byte,
  output tspp_pkg::tspp_pid_req_t               pid_req,
  output logic [COUNT_BITS+3:0]                 pid_wr_data,
  input  wire  [COUNT_BITS+3:0]                 pid_rd_data,
  output logic                                  push,
  output tspp_pkg::tspp_rec_t                   rec_out
);

  localparam int SLOT_BITS = (PROGRAM_SLOTS > 1) ? $clog2(PROGRAM_SLOTS) : 1;

  // configuration
  logic [15:0] packet_limit;
  logic [3:0]  pes_limit;

  // parser state
  logic [7:0]  pos, pos_next;
  logic        halted, halted_next;
  logic [15:0] seen, seen_next;
  logic [12:0] cur_pid, pid_next;
  logic        cur_us, us_next;
  logic [8:0]  pb, pb_next;
  logic [11:0] sl, sl_next;
  logic [8:0]  eb, eb_next;
  logic [39:0] win, win_next;
  logic [1:0]  flags, flags_next;
  logic [7:0]  sid, sid_next;
  logic [32:0] pts, pts_next;
  logic [32:0] dts, dts_next;
  logic        adapt, adapt_next;
  tspp_pkg::tspp_mode_t mode, mode_next;
  logic        tl, tl_next;
  logic [8:0]  sb, sb_next;
  logic [11:0] il, il_next;
  logic        pl, pl_next;
  logic        waiting, waiting_next;
  tspp_pkg::tspp_rec_t pes_rec, pes_rec_next;

  // working copy of this packet's counters
  logic                  fresh;
  logic [COUNT_BITS-1:0] pkt_cnt, rd_pkt, pkt_inc, eff_pkt;
  logic [3:0]            pes_cnt, rd_pes, eff_pes, pes_inc;
  logic                  pes_done;

  // program table
  logic [15:0] prog_num [PROGRAM_SLOTS];
  logic [12:0] prog_pmt [PROGRAM_SLOTS];
  logic        prog_valid [PROGRAM_SLOTS];
  logic        store_en;
  logic [15:0] store_prog;
  logic [12:0] store_pmt;
  logic                 hit, free_any, pmt_match;
  logic [SLOT_BITS-1:0] hit_idx, free_idx;
  logic [12:0]          full_pid;

  logic rd_issue;

  assign rd_pkt  = pid_rd_data[COUNT_BITS+3:4];
  assign rd_pes  = pid_rd_data[3:0];
  assign pkt_inc = (rd_pkt == '1) ? rd_pkt : rd_pkt + 1'b1;
  assign eff_pkt = fresh ? pkt_inc : pkt_cnt;
  assign eff_pes = fresh ? rd_pes : pes_cnt;
  assign pes_inc = (eff_pes == 4'hF) ? eff_pes : eff_pes + 4'd1;
  assign full_pid = {cur_pid[12:8], data_byte};
  assign rd_issue = acc && !halted && (pos == 8'd2);

  always_comb begin
    pid_req.rd_en   = rd_issue;
    pid_req.rd_addr = full_pid;
    pid_req.wr_en   = fresh || pes_done;
    pid_req.wr_addr = cur_pid;
    pid_wr_data     = fresh ? {pkt_inc, rd_pes} : {pkt_cnt, pes_inc};
  end

  // table lookups
  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    free_any = 1'b0;
    free_idx = '0;
    pmt_match = 1'b0;
    for (int i = PROGRAM_SLOTS - 1; i >= 0; i--) begin
      if (prog_valid[i] && prog_num[i] == store_prog) begin
        hit = 1'b1;
        hit_idx = SLOT_BITS'(i);
      end
      if (!prog_valid[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_BITS'(i);
      end
      if (prog_valid[i] && prog_pmt[i] == full_pid) pmt_match = 1'b1;
    end
  end

  function automatic tspp_pkg::tspp_rec_t base_rec(input tspp_pkg::tspp_kind_t k);
    tspp_pkg::tspp_rec_t r;
    r = '0;
    r.kind = k;
    r.pid = cur_pid;
    r.unit_start = cur_us;
    r.index = seen;
    return r;
  endfunction

  always_comb begin
    logic [7:0]  b;
    logic [7:0]  off;
    logic [7:0]  d;
    logic [12:0] sum13;
    logic        fin;
    logic        have_main;
    logic        want_pts;
    logic        want_dts;
    tspp_pkg::tspp_rec_t main_rec;
    tspp_pkg::tspp_rec_t fin_rec;

    b = data_byte;
    off = '0;
    d = '0;
    sum13 = '0;
    fin = 1'b0;
    have_main = 1'b0;
    want_pts = 1'b0;
    want_dts = 1'b0;
    main_rec = '0;
    fin_rec = '0;

    pos_next = pos; halted_next = halted; seen_next = seen;
    pid_next = cur_pid; us_next = cur_us; pb_next = pb; sl_next = sl;
    eb_next = eb; win_next = win; flags_next = flags; sid_next = sid;
    pts_next = pts; dts_next = dts; adapt_next = adapt; mode_next = mode;
    tl_next = tl; sb_next = sb; il_next = il; pl_next = pl;
    waiting_next = waiting; pes_rec_next = pes_rec;
    push = 1'b0; rec_out = pes_rec;
    store_en = 1'b0; store_prog = '0; store_pmt = '0;

    if (acc && !halted) begin
      win_next = {win[31:0], b};
      pos_next = (pos >= tspp_pkg::PKT_LAST) ? 8'd0 : pos + 8'd1;
      if (pos == 8'd0) begin
        if (seen >= packet_limit) begin
          halted_next = 1'b1;
          push = waiting;
          waiting_next = 1'b0;
        end else if (b != tspp_pkg::SYNC_BYTE) begin
          halted_next = 1'b1;
          waiting_next = 1'b0;
          rec_out = '0;
          rec_out.kind = tspp_pkg::KIND_SYNC;
          rec_out.index = seen;
          push = 1'b1;
        end else begin
          push = waiting;
          waiting_next = 1'b0;
        end
      end else if (pos == 8'd1) begin
        us_next = b[6];
        pid_next = {b[4:0], 8'h00};
        pl_next = 1'b0;
        tl_next = 1'b0;
        push = waiting;
        waiting_next = 1'b0;
      end else if (pos == 8'd2) begin
        pid_next = full_pid;
        if (full_pid == 13'd0) mode_next = tspp_pkg::MODE_PAT;
        else if (pmt_match) mode_next = tspp_pkg::MODE_PMT;
        else mode_next = tspp_pkg::MODE_NONE;
        push = waiting;
        waiting_next = 1'b0;
      end else begin
        if (pos == 8'd3) begin
          adapt_next = b[5];
          pb_next = 9'd4;
          main_rec = base_rec(tspp_pkg::KIND_HEADER);
          main_rec.pkt_count = 16'(eff_pkt);
          have_main = 1'b1;
        end else if (pos == 8'd4 && adapt) begin
          pb_next = 9'd5 + {1'b0, b};
        end else if ({1'b0, pos} >= pb_next) begin
          off = pos - pb_next[7:0];
          if (off == 8'd0) begin
            sb_next = (b == 8'd0) ? {1'b0, pos} + 9'd1 : {1'b0, pos};
            tl_next = (mode == tspp_pkg::MODE_PAT && {1'b0, sb_next} + 10'd7 < 10'd188) ||
                      (mode == tspp_pkg::MODE_PMT && {1'b0, sb_next} + 10'd11 < 10'd188);
            pl_next = cur_us && ({1'b0, pb_next} + 10'd8 < 10'd188) && (b == 8'd0) &&
                      (eff_pes < pes_limit);
          end
          if (pl_next) begin
            if ((off == 8'd1 && b != 8'd0) || (off == 8'd2 && b != 8'd1)) begin
              pl_next = 1'b0;
            end else if (off == 8'd3) begin
              sid_next = b;
              pts_next = '0;
              dts_next = '0;
              flags_next = 2'b00;
            end else if (off == 8'd7) begin
              flags_next = b[7:6];
            end else if (off == 8'd8) begin
              want_pts = tspp_pkg::pes_has_ext(sid_next) &&
                         ({1'b0, pb_next} + 10'd13 < 10'd188) && flags_next[1];
              want_dts = want_pts && (flags_next == 2'b11) &&
                         ({1'b0, pb_next} + 10'd18 < 10'd188);
              flags_next = {want_pts, want_dts};
              fin = !want_pts;
            end else if (off == 8'd13 && flags_next[1]) begin
              pts_next = tspp_pkg::ts_from_window(win_next);
              fin = !flags_next[0];
            end else if (off == 8'd18 && flags_next[0]) begin
              dts_next = tspp_pkg::ts_from_window(win_next);
              fin = 1'b1;
            end
          end
          if (fin) begin
            fin_rec = base_rec(tspp_pkg::KIND_PES);
            fin_rec.id = {8'h00, sid_next};
            fin_rec.has_pts = flags_next[1];
            fin_rec.pts = pts_next;
            fin_rec.has_dts = flags_next[0];
            fin_rec.dts = dts_next;
            pl_next = 1'b0;
          end
          if (tl_next && {1'b0, pos} >= sb_next) begin
            d = pos - sb_next[7:0];
            if (d == 8'd1) begin
              sl_next = {b[3:0], 8'h00};
            end else if (d == 8'd2) begin
              sl_next = {sl_next[11:8], b};
              if (mode == tspp_pkg::MODE_PAT) eb_next = sb_next + 9'd8;
            end else if (mode == tspp_pkg::MODE_PMT && d == 8'd10) begin
              il_next = {b[3:0], 8'h00};
            end else if (mode == tspp_pkg::MODE_PMT && d == 8'd11) begin
              il_next = {il_next[11:8], b};
              sum13 = {4'b0, sb_next} + 13'd12 + {1'b0, il_next};
              eb_next = (sum13 > 13'd511) ? 9'd511 : sum13[8:0];
            end
            if (mode == tspp_pkg::MODE_PAT && d >= 8'd8) begin
              if ({1'b0, pos} == eb_next &&
                  !(({5'b0, pos} < {4'b0, sb_next} + {1'b0, sl_next}) &&
                    ({2'b0, pos} + 10'd3 < 10'd188)))
                tl_next = 1'b0;
              if (tl_next && {2'b0, pos} == {1'b0, eb_next} + 10'd3) begin
                eb_next = eb_next + 9'd4;
                if (win_next[31:16] != 16'd0) begin
                  store_en = 1'b1;
                  store_prog = win_next[31:16];
                  store_pmt = win_next[12:0];
                  main_rec = base_rec(tspp_pkg::KIND_PAT);
                  main_rec.id = win_next[31:16];
                  main_rec.linked = win_next[12:0];
                  have_main = 1'b1;
                end
              end
            end else if (mode == tspp_pkg::MODE_PMT && d >= 8'd12) begin
              if ({1'b0, pos} == eb_next &&
                  !(({5'b0, pos} + 13'd1 < {4'b0, sb_next} + {1'b0, sl_next}) &&
                    ({2'b0, pos} + 10'd4 < 10'd188)))
                tl_next = 1'b0;
              if (tl_next && {2'b0, pos} == {1'b0, eb_next} + 10'd4) begin
                main_rec = base_rec(tspp_pkg::KIND_PMT);
                main_rec.id = {8'h00, win_next[39:32]};
                main_rec.linked = win_next[28:16];
                have_main = 1'b1;
                sum13 = {4'b0, eb_next} + 13'd5 + {1'b0, win_next[11:0]};
                eb_next = (sum13 > 13'd511) ? 9'd511 : sum13[8:0];
              end
            end
          end
        end
        if (pos == tspp_pkg::PKT_LAST) begin
          if (seen != 16'hFFFF) seen_next = seen + 16'd1;
          pl_next = 1'b0;
          tl_next = 1'b0;
        end
        if (have_main) begin
          push = 1'b1;
          rec_out = main_rec;
          if (fin) begin
            pes_rec_next = fin_rec;
            waiting_next = 1'b1;
          end
        end else if (fin) begin
          push = 1'b1;
          rec_out = fin_rec;
          waiting_next = 1'b0;
        end else begin
          push = waiting;
          waiting_next = 1'b0;
        end
      end
    end
    pes_done = fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_limit <= tspp_pkg::PACKET_LIMIT_RESET;
      pes_limit <= tspp_pkg::PES_LIMIT_RESET;
      pos <= '0; halted <= 1'b0; seen <= '0; cur_pid <= '0; cur_us <= 1'b0;
      pb <= 9'd4; sl <= '0; eb <= '0; win <= '0; flags <= '0; sid <= '0;
      pts <= '0; dts <= '0; adapt <= 1'b0; mode <= tspp_pkg::MODE_NONE;
      tl <= 1'b0; sb <= '0; il <= '0; pl <= 1'b0; waiting <= 1'b0;
      fresh <= 1'b0;
    end else begin
      if (cfg_write && cfg_index == tspp_pkg::CFG_PACKET_LIMIT)
        packet_limit <= cfg_data;
      if (cfg_write && cfg_index == tspp_pkg::CFG_PES_LIMIT)
        pes_limit <= cfg_data[3:0];
      pos <= pos_next; halted <= halted_next; seen <= seen_next;
      cur_pid <= pid_next; cur_us <= us_next; pb <= pb_next; sl <= sl_next;
      eb <= eb_next; win <= win_next; flags <= flags_next; sid <= sid_next;
      pts <= pts_next; dts <= dts_next; adapt <= adapt_next; mode <= mode_next;
      tl <= tl_next; sb <= sb_next; il <= il_next; pl <= pl_next;
      waiting <= waiting_next;
      fresh <= rd_issue;
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    pes_rec <= pes_rec_next;
    if (fresh) begin
      pkt_cnt <= pkt_inc;
      pes_cnt <= rd_pes;
    end else if (pes_done) begin
      pes_cnt <= pes_inc;
    end
    if (store_en) begin
      if (hit) begin
        prog_pmt[hit_idx] <= store_pmt;
      end else if (free_any) begin
        prog_num[free_idx] <= store_prog;
        prog_pmt[free_idx] <= store_pmt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PROGRAM_SLOTS; i++) prog_valid[i] <= 1'b0;
    end else if (store_en && !hit && free_any) begin
      prog_valid[free_idx] <= 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: design/transport_stream_packet_parser.sv
// Transport stream packet parser, top level. Depends on tspp_pkg, tspp_if,
// tspp_pidmem, tspp_outq and tspp_core.
//
// Takes an aligned 188-byte transport stream at one byte per cycle while not
// stalled and sends one record per header, nonzero PAT program, PMT stream and
// PES header (up to the PES limit per PID), plus a single sync-error record.
// The parser keeps taking bytes while fewer than two finished records wait in
// the output queue, and stalls when that queue is full. Per-PID packet and PES
// counts sit in an 8192-entry memory that is read when the PID completes
// (byte 2) and written back the cycle after, and again when a PES header
// completes. After reset the memory is cleared one entry a cycle, during which
// no byte is taken; configuration writes are still taken meanwhile. A sync
// error or the packet limit stops the parser until the next reset.
`default_nettype none
module transport_stream_packet_parser #(
  parameter int PROGRAM_SLOTS = 16,
  parameter int COUNT_BITS    = 16
) (
  input  wire                                  clk,
  input  wire                                  rst,
  tspp_byte_if.sink                            stream,
  tspp_rec_if.source                           records,
  input  wire                                  cfg_write,
  input  wire  [tspp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire  [tspp_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  tspp_pkg::tspp_pid_req_t pid_req;
  logic [COUNT_BITS+3:0]   pid_wr_data;
  logic [COUNT_BITS+3:0]   pid_rd_data;
  logic                    clearing;
  logic                    space;
  logic                    acc;
  logic                    push;
  tspp_pkg::tspp_rec_t     rec_in;
  tspp_pkg::tspp_rec_t     head;

  // take a byte only with queue room and the counter memory cleared
  assign stream.ready = space && !clearing;
  assign acc = stream.valid && stream.ready;

  tspp_pidmem #(.COUNT_BITS(COUNT_BITS)) u_pidmem (
    .clk      (clk),
    .rst      (rst),
    .req      (pid_req),
    .wr_data  (pid_wr_data),
    .rd_data  (pid_rd_data),
    .clearing (clearing)
  );

  tspp_core #(.PROGRAM_SLOTS(PROGRAM_SLOTS), .COUNT_BITS(COUNT_BITS)) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .acc         (acc),
    .data_byte   (stream.data_byte),
    .pid_req     (pid_req),
    .pid_wr_data (pid_wr_data),
    .pid_rd_data (pid_rd_data),
    .push        (push),
    .rec_out     (rec_in)
  );

  // hold finished records until the output transfer completes
  tspp_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (rec_in),
    .space (space),
    .valid (records.valid),
    .ready (records.ready),
    .head  (head)
  );

  assign records.record_kind      = head.kind;
  assign records.packet_pid       = head.pid;
  assign records.unit_start       = head.unit_start;
  assign records.pid_packet_count = head.pkt_count;
  assign records.packet_index     = head.index;
  assign records.id_value         = head.id;
  assign records.linked_pid       = head.linked;
  assign records.has_pts          = head.has_pts;
  assign records.pts              = head.pts;
  assign records.has_dts          = head.has_dts;
  assign records.dts              = head.dts;

endmodule
`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for transport_stream_packet_parser: aligned transport packets in,
// header/PAT/PMT/PES/sync records out, each compared with an in-bench parser model.
// Depends on tspp_pkg, tspp_if and the parser RTL.
`timescale 1ns / 1ps
module tb;

  localparam int LAST = 187;

  // Kinds of packet payload the stimulus builder knows how to lay out.
  typedef enum int {
    PL_RAND, PL_PAT, PL_PAT_FULL, PL_PMT, PL_PES_BOTH, PL_PES_PTS,
    PL_PES_NOEXT, PL_PES_NONE, PL_COLLIDE
  } payload_e;

  typedef struct {
    logic [12:0] pid;
    bit          pusi;
    int          afl;       // adaptation field length, -1 for none
    payload_e    body;
    int          hdr_count; // typed pid_packet_count of the header record, -1 if not typed
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [tspp_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [tspp_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

  tspp_byte_if stream_if ();
  tspp_rec_if  rec_if ();

  transport_stream_packet_parser u_dut (
    .clk       (clk),
    .rst       (rst),
    .stream    (stream_if),
    .records   (rec_if),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Parser model state: mirrors what the block keeps per byte.
  // ---------------------------------------------------------------------------
  logic [15:0] lim_packets;
  logic [3:0]  lim_pes;
  int          pos;
  bit          halted;
  logic [15:0] seen_pkts;
  logic [15:0] pid_pkts [tspp_pkg::PID_SPACE];
  logic [3:0]  pid_pes [tspp_pkg::PID_SPACE];
  logic [15:0] slot_prog [16];
  logic [12:0] slot_pmt [16];
  bit          slot_used [16];
  logic [12:0] cur_pid;
  bit          cur_us;
  int          pay_begin, sec_len, entry_begin, sec_begin, info_len;
  logic [39:0] win;
  logic [1:0]  ts_flags;
  logic [7:0]  pes_sid;
  logic [32:0] pts_hold, dts_hold;
  bit          adapt, table_live, pes_live, pes_waiting;
  tspp_pkg::tspp_mode_t tbl_mode;
  tspp_pkg::tspp_rec_t  pes_rec;

  tspp_pkg::tspp_rec_t records_due[$];   // expected records, oldest first
  int        typed_hdr[$];     // typed header counts of the directed packets
  logic [7:0] tx_q[$];         // bytes still to be offered
  int        fail_count = 0;
  int        hold_req = 0;

  function automatic void report(input string what, input logic [39:0] e, input logic [39:0] a);
    $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, e, a);
    fail_count++;
  endfunction

  function automatic void parser_reset();
    lim_packets = tspp_pkg::PACKET_LIMIT_RESET;
    lim_pes = tspp_pkg::PES_LIMIT_RESET;
    pos = 0; halted = 0; seen_pkts = '0;
    foreach (pid_pkts[i]) begin
      pid_pkts[i] = '0;
      pid_pes[i] = '0;
    end
    foreach (slot_used[i]) begin
      slot_used[i] = 0; slot_prog[i] = '0; slot_pmt[i] = '0;
    end
    cur_pid = '0; cur_us = 0; pay_begin = 4; sec_len = 0; entry_begin = 0;
    sec_begin = 0; info_len = 0; win = '0; ts_flags = '0; pes_sid = '0;
    pts_hold = '0; dts_hold = '0; adapt = 0; table_live = 0; pes_live = 0;
    pes_waiting = 0; tbl_mode = tspp_pkg::MODE_NONE; pes_rec = '0;
  endfunction

  function automatic logic [32:0] window_to_ts(input logic [39:0] w);
    logic [32:0] t;
    t = '0;
    t[32:30] = w[35:33];
    t[29:22] = w[31:24];
    t[21:15] = w[23:17];
    t[14:7]  = w[15:8];
    t[6:0]   = w[7:1];
    return t;
  endfunction

  function automatic tspp_pkg::tspp_rec_t base_rec(input tspp_pkg::tspp_kind_t k);
    tspp_pkg::tspp_rec_t r;
    r = '0;
    r.kind = k;
    r.pid = cur_pid;
    r.unit_start = cur_us;
    r.index = seen_pkts;
    return r;
  endfunction

  // Update an existing program, else take the lowest free slot, else drop.
  function automatic void store_program(input logic [15:0] prog, input logic [12:0] pmt);
    for (int i = 0; i < 16; i++)
      if (slot_used[i] && slot_prog[i] == prog) begin
        slot_pmt[i] = pmt;
        return;
      end
    for (int i = 0; i < 16; i++)
      if (!slot_used[i]) begin
        slot_used[i] = 1; slot_prog[i] = prog; slot_pmt[i] = pmt;
        return;
      end
  endfunction

  function automatic bit pmt_known(input logic [12:0] pid);
    for (int i = 0; i < 16; i++)
      if (slot_used[i] && slot_pmt[i] == pid) return 1;
    return 0;
  endfunction

  function automatic void close_pes();
    if (pid_pes[cur_pid] != 4'hF) pid_pes[cur_pid]++;
    pes_rec = base_rec(tspp_pkg::KIND_PES);
    pes_rec.id = {8'h00, pes_sid};
    pes_rec.has_pts = ts_flags[1];
    pes_rec.pts = pts_hold;
    pes_rec.has_dts = ts_flags[0];
    pes_rec.dts = dts_hold;
    pes_live = 0;
  endfunction

  function automatic void release_held(output bit got, output tspp_pkg::tspp_rec_t r);
    got = pes_waiting;
    r = pes_rec;
    pes_waiting = 0;
  endfunction

  // Advance the parser model by one stream byte; got says whether a record leaves.
  function automatic void parse_byte(input logic [7:0] b, output bit got,
                                     output tspp_pkg::tspp_rec_t r);
    int at, off, d, tv;
    bit have_main, pes_done, ext, want_pts, want_dts;
    tspp_pkg::tspp_rec_t rec;
    got = 0; r = '0; have_main = 0; pes_done = 0; rec = '0;
    if (halted) return;
    win = {win[31:0], b};
    at = pos;
    pos = (at >= LAST) ? 0 : at + 1;

    if (at == 0) begin
      if (seen_pkts >= lim_packets) begin
        halted = 1;
        release_held(got, r);
        return;
      end
      if (b != tspp_pkg::SYNC_BYTE) begin
        halted = 1;
        pes_waiting = 0;
        r = '0;
        r.kind = tspp_pkg::KIND_SYNC;
        r.index = seen_pkts;
        got = 1;
        return;
      end
      release_held(got, r);
      return;
    end
    if (at == 1) begin
      cur_us = b[6];
      cur_pid = {b[4:0], 8'h00};
      pes_live = 0;
      table_live = 0;
      release_held(got, r);
      return;
    end
    if (at == 2) begin
      cur_pid[7:0] = b;
      if (pid_pkts[cur_pid] != 16'hFFFF) pid_pkts[cur_pid]++;
      tbl_mode = (cur_pid == 0) ? tspp_pkg::MODE_PAT :
                 (pmt_known(cur_pid) ? tspp_pkg::MODE_PMT : tspp_pkg::MODE_NONE);
      release_held(got, r);
      return;
    end

    if (at == 3) begin
      adapt = b[5];
      pay_begin = 4;
      rec = base_rec(tspp_pkg::KIND_HEADER);
      rec.pkt_count = pid_pkts[cur_pid];
      have_main = 1;
      if (typed_hdr.size() > 0) begin
        tv = typed_hdr.pop_front();
        if (tv >= 0 && tv != int'(pid_pkts[cur_pid]))
          report("typed header count", tv, pid_pkts[cur_pid]);
      end
    end else if (at == 4 && adapt) begin
      pay_begin = 5 + int'(b);
    end else if (at >= pay_begin) begin
      off = at - pay_begin;
      if (off == 0) begin
        sec_begin = (b == 0) ? at + 1 : at;
        table_live = (tbl_mode == tspp_pkg::MODE_PAT && sec_begin + 7 < 188) ||
                     (tbl_mode == tspp_pkg::MODE_PMT && sec_begin + 11 < 188);
        pes_live = cur_us && pay_begin + 8 < 188 && b == 0 && pid_pes[cur_pid] < lim_pes;
      end
      if (pes_live) begin
        if ((off == 1 && b != 0) || (off == 2 && b != 1)) begin
          pes_live = 0;
        end else if (off == 3) begin
          pes_sid = b;
          pts_hold = '0; dts_hold = '0; ts_flags = '0;
        end else if (off == 7) begin
          ts_flags = b[7:6];
        end else if (off == 8) begin
          case (pes_sid)
            8'hBC, 8'hBE, 8'hBF, 8'hF0, 8'hF1, 8'hF2, 8'hF8, 8'hFF: ext = 0;
            default: ext = 1;
          endcase
          want_pts = ext && pay_begin + 13 < 188 && ts_flags[1];
          want_dts = want_pts && ts_flags == 2'b11 && pay_begin + 18 < 188;
          ts_flags = {want_pts, want_dts};
          if (!want_pts) begin
            close_pes();
            pes_done = 1;
          end
        end else if (off == 13 && ts_flags[1]) begin
          pts_hold = window_to_ts(win);
          if (!ts_flags[0]) begin
            close_pes();
            pes_done = 1;
          end
        end else if (off == 18 && ts_flags[0]) begin
          dts_hold = window_to_ts(win);
          close_pes();
          pes_done = 1;
        end
      end
      if (table_live && at >= sec_begin) begin
        d = at - sec_begin;
        if (d == 1) begin
          sec_len = int'(b[3:0]) << 8;
        end else if (d == 2) begin
          sec_len = sec_len | int'(b);
          if (tbl_mode == tspp_pkg::MODE_PAT) entry_begin = sec_begin + 8;
        end else if (tbl_mode == tspp_pkg::MODE_PMT && d == 10) begin
          info_len = int'(b[3:0]) << 8;
        end else if (tbl_mode == tspp_pkg::MODE_PMT && d == 11) begin
          info_len = info_len | int'(b);
          entry_begin = sec_begin + 12 + info_len;
          if (entry_begin > 511) entry_begin = 511;
        end
        if (tbl_mode == tspp_pkg::MODE_PAT && d >= 8) begin
          if (at == entry_begin && !(at < sec_begin + sec_len && at + 3 < 188))
            table_live = 0;
          if (table_live && at == entry_begin + 3) begin
            entry_begin += 4;
            if (win[31:16] != 0) begin
              store_program(win[31:16], win[12:0]);
              rec = base_rec(tspp_pkg::KIND_PAT);
              rec.id = win[31:16];
              rec.linked = win[12:0];
              have_main = 1;
            end
          end
        end else if (tbl_mode == tspp_pkg::MODE_PMT && d >= 12) begin
          if (at == entry_begin && !(at + 1 < sec_begin + sec_len && at + 4 < 188))
            table_live = 0;
          if (table_live && at == entry_begin + 4) begin
            rec = base_rec(tspp_pkg::KIND_PMT);
            rec.id = {8'h00, win[39:32]};
            rec.linked = win[28:16];
            have_main = 1;
            entry_begin = entry_begin + 5 + int'(win[11:0]);
            if (entry_begin > 511) entry_begin = 511;
          end
        end
      end
    end

    if (at == LAST) begin
      if (seen_pkts != 16'hFFFF) seen_pkts++;
      pes_live = 0;
      table_live = 0;
    end

    // A PES record that finishes under another record waits for a free byte.
    if (pes_done) pes_waiting = 1;
    if (have_main) begin
      got = 1;
      r = rec;
      return;
    end
    release_held(got, r);
  endfunction

  // ---------------------------------------------------------------------------
  // Packet builder: lays one 188-byte packet out in pkt, then queues it.
  // ---------------------------------------------------------------------------
  logic [7:0] pkt [188];
  int         wr;

  function automatic void put(input logic [7:0] v);
    if (wr < 188) begin
      pkt[wr] = v;
      wr++;
    end
  endfunction

  function automatic void begin_pkt(input logic [12:0] pid, input bit pusi, input int afl);
    logic [31:0] rv;
    rv = $urandom;
    for (int i = 0; i < 188; i++) pkt[i] = 8'($urandom);
    wr = 0;
    put(tspp_pkg::SYNC_BYTE);
    put({rv[0], pusi, rv[1], pid[12:8]});
    put(pid[7:0]);
    put({rv[3:2], (afl >= 0) ? 2'b11 : 2'b01, rv[7:4]});
    if (afl >= 0) begin
      put(afl[7:0]);
      for (int i = 0; i < afl; i++) put(8'($urandom));
    end
  endfunction

  function automatic void end_pkt();
    for (int i = 0; i < 188; i++) tx_q.push_back(pkt[i]);
  endfunction

  function automatic void patch_len(input int at, input int len);
    logic [11:0] l;
    l = len[11:0];
    if (at + 1 < 188) begin
      pkt[at] = {4'hB, l[11:8]};
      pkt[at + 1] = l[7:0];
    end
  endfunction

  // PAT section; first_prog > 0 numbers the programs consecutively.
  function automatic void build_pat(input int n, input int first_prog, input bit sloppy);
    int start, lenpos;
    logic [15:0] prog;
    logic [12:0] pmt;
    logic [31:0] rv;
    rv = $urandom;
    put((sloppy && rv[0]) ? rv[15:8] : 8'h00);
    start = wr;
    put(8'h00);
    lenpos = wr;
    put(8'h00); put(8'h00);
    put(rv[23:16]); put(rv[31:24]); put(8'hC1); put(8'h00); put(8'h00);
    for (int i = 0; i < n; i++) begin
      if (first_prog > 0) begin
        prog = 16'(first_prog + i);
        pmt = 13'(16 + i % 8);
      end else begin
        prog = (i == 0) ? 16'd0 : 16'($urandom_range(0, 30));
        pmt = (i == 1 || $urandom_range(0, 9) == 0) ? 13'd0 : 13'(16 + $urandom_range(0, 7));
      end
      put(prog[15:8]); put(prog[7:0]); put({3'b111, pmt[12:8]}); put(pmt[7:0]);
    end
    repeat (4) put(8'($urandom));
    patch_len(lenpos, sloppy ? int'($urandom_range(0, 4095)) : wr - start - 3);
  endfunction

  function automatic void build_pmt(input bit sloppy);
    int start, lenpos, il, esl, n;
    logic [31:0] rv;
    rv = $urandom;
    put(8'h00);
    start = wr;
    put(8'h02);
    lenpos = wr;
    put(8'h00); put(8'h00);
    put(rv[7:0]); put(rv[15:8]); put(8'hC1); put(8'h00); put(8'h00);
    put({3'b111, rv[20:16]}); put(rv[31:24]);
    il = $urandom_range(0, 3);
    put(8'hF0); put(8'(il));
    repeat (il) put(8'($urandom));
    n = $urandom_range(1, 6);
    repeat (n) begin
      rv = $urandom;
      esl = $urandom_range(0, 2);
      put(rv[7:0]); put({3'b111, rv[12:8]}); put(rv[23:16]); put(8'hF0); put(8'(esl));
      repeat (esl) put(8'($urandom));
    end
    repeat (4) put(8'($urandom));
    patch_len(lenpos, sloppy ? int'($urandom_range(0, 4095)) : wr - start - 3);
  endfunction

  function automatic void build_pes(input logic [7:0] sid, input logic [1:0] flg, input bit broken);
    logic [31:0] rv;
    rv = $urandom;
    put(8'h00);
    put((broken && rv[0]) ? 8'h02 : 8'h00);
    put((broken && !rv[0]) ? 8'h80 : 8'h01);
    put(sid); put(rv[15:8]); put(rv[23:16]); put(8'h80);
    put({flg, rv[29:24]});
    put(8'd10);
    repeat (10) put(8'($urandom));
  endfunction

  // PES header on a PMT PID, laid out so that its DTS completes on the same
  // byte as a stream entry of the section that the parser also sees there.
  function automatic void build_collision();
    logic [31:0] rv;
    rv = $urandom;
    put(8'h00); put(8'h00); put(8'h01); put(8'hE0); put(rv[7:0]); put(rv[15:8]);
    put(8'h80); put(8'hC0); put(8'h0A);
    put(rv[23:16]); put(rv[31:24]); put({4'($urandom), 4'h0}); put(8'h01); put(8'($urandom));
    repeat (5) put(8'($urandom));
  endfunction

  function automatic logic [7:0] pick_sid();
    logic [7:0] ids [11] = '{8'hE0, 8'hC0, 8'hBD, 8'hBC, 8'hBE, 8'hBF,
                             8'hF0, 8'hF1, 8'hF2, 8'hF8, 8'hFF};
    int k;
    k = $urandom_range(0, 11);
    return (k == 11) ? 8'($urandom) : ids[k];
  endfunction

  function automatic void add_packet(input logic [12:0] pid, input bit pusi, input int afl,
                                     input payload_e body);
    begin_pkt(pid, pusi, afl);
    case (body)
      PL_PAT:       build_pat($urandom_range(2, 10), 0, 0);
      PL_PAT_FULL:  build_pat(20, 100, 0);
      PL_PMT:       build_pmt(0);
      PL_PES_BOTH:  build_pes(8'hE0, 2'b11, 0);
      PL_PES_PTS:   build_pes(8'hC0, 2'b10, 0);
      PL_PES_NOEXT: build_pes(8'hBC, 2'b11, 0);
      PL_PES_NONE:  build_pes(8'hE1, 2'b00, 0);
      PL_COLLIDE:   build_collision();
      default: ;
    endcase
    end_pkt();
  endfunction

  // Mostly well-formed tables and PES headers with random content, some noise.
  function automatic void add_random_packet();
    logic [31:0] rv;
    int afl, sel;
    rv = $urandom;
    sel = rv % 100;
    afl = -1;
    if (rv[9:7] == 0) afl = $urandom_range(0, 20);
    else if (rv[12:10] == 0) afl = $urandom_range(150, 255);
    if (sel < 12) begin
      begin_pkt(13'd0, 1, afl);
      build_pat($urandom_range(1, 12), 0, rv[17:16] == 0);
    end else if (sel < 35) begin
      begin_pkt(13'(16 + rv[15:13]), 1, afl);
      build_pmt(rv[19:18] == 0);
    end else if (sel < 65) begin
      begin_pkt(13'(13'h100 + rv[15:13] % 6), rv[22:20] != 0, afl);
      build_pes(pick_sid(), rv[24:23], rv[27:25] == 0);
    end else if (sel < 72) begin
      begin_pkt(13'(16 + rv[15:13]), 1, -1);
      build_collision();
    end else begin
      begin_pkt(rv[28:16], rv[29], afl);
    end
    end_pkt();
  endfunction

  // ---------------------------------------------------------------------------
  // Byte sender and record checker share one process, so the model sees each
  // accepted byte before the record it causes can be compared.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    bit got;
    tspp_pkg::tspp_rec_t want, seen_r;
    if (rst) begin
      stream_if.valid <= 1'b0;
    end else begin
      if (stream_if.valid && stream_if.ready) begin
        parse_byte(stream_if.data_byte, got, want);
        if (got) records_due.push_back(want);
      end
      if (rec_if.valid && rec_if.ready) begin
        seen_r.kind = tspp_pkg::tspp_kind_t'(rec_if.record_kind);
        seen_r.pid = rec_if.packet_pid;
        seen_r.unit_start = rec_if.unit_start;
        seen_r.pkt_count = rec_if.pid_packet_count;
        seen_r.index = rec_if.packet_index;
        seen_r.id = rec_if.id_value;
        seen_r.linked = rec_if.linked_pid;
        seen_r.has_pts = rec_if.has_pts;
        seen_r.pts = rec_if.pts;
        seen_r.has_dts = rec_if.has_dts;
        seen_r.dts = rec_if.dts;
        if (records_due.size() == 0) begin
          $display("%0t: unexpected record, expected none actual kind %0d pid %0h",
                   $time, rec_if.record_kind, rec_if.packet_pid);
          fail_count++;
        end else begin
          want = records_due.pop_front();
          if (seen_r.kind != want.kind) report("record_kind", want.kind, seen_r.kind);
          if (seen_r.pid != want.pid) report("packet_pid", want.pid, seen_r.pid);
          if (seen_r.unit_start != want.unit_start)
            report("unit_start", want.unit_start, seen_r.unit_start);
          if (seen_r.pkt_count != want.pkt_count)
            report("pid_packet_count", want.pkt_count, seen_r.pkt_count);
          if (seen_r.index != want.index) report("packet_index", want.index, seen_r.index);
          if (seen_r.id != want.id) report("id_value", want.id, seen_r.id);
          if (seen_r.linked != want.linked) report("linked_pid", want.linked, seen_r.linked);
          if (seen_r.has_pts != want.has_pts) report("has_pts", want.has_pts, seen_r.has_pts);
          if (seen_r.pts != want.pts) report("pts", want.pts, seen_r.pts);
          if (seen_r.has_dts != want.has_dts) report("has_dts", want.has_dts, seen_r.has_dts);
          if (seen_r.dts != want.dts) report("dts", want.dts, seen_r.dts);
        end
      end
      // Offer the next byte in bursts; hold the current one while stalled.
      if (!stream_if.valid || stream_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          stream_if.valid <= 1'b0;
        end else if (tx_q.size() > 0) begin
          stream_if.valid <= 1'b1;
          stream_if.data_byte <= tx_q.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 40);
            gap_left = $urandom_range(1, 6);
          end
        end else begin
          stream_if.valid <= 1'b0;
        end
      end
    end
  end

  // Record receiver: open stretches, random stalls, and long hold-offs on request.
  int rx_phase = 0;
  int hold_left = 0;
  int hold_done = 0;

  always @(posedge clk) begin
    if (rst) begin
      rec_if.ready <= 1'b0;
    end else begin
      rx_phase = (rx_phase + 1) % 97;
      if (hold_req != hold_done) begin
        hold_done++;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        rec_if.ready <= 1'b0;
      end else if (rx_phase < 30) begin
        rec_if.ready <= 1'b1;
      end else begin
        rec_if.ready <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  // Write one register; the model follows once the write has landed.
  task automatic write_reg(input logic [tspp_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [15:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == tspp_pkg::CFG_PACKET_LIMIT) lim_packets = val;
    else lim_pes = val[3:0];
  endtask

  // Drain: every byte taken and every expected record seen, then let a held
  // PES record or a late write-back settle.
  task automatic drain();
    while (tx_q.size() != 0 || stream_if.valid || records_due.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Directed packets: tables, PES headers, bounds and collisions.
  // ---------------------------------------------------------------------------
  plan_row_t plan [6] = '{
    '{13'h0000, 1, -1,  PL_PAT_FULL,  1},  // fills the program table, drops the rest
    '{13'h0000, 1, -1,  PL_PAT,       2},  // program 0 and PMT PID 0 entries
    '{13'h0010, 1, -1,  PL_PMT,       1},
    '{13'h0100, 1, -1,  PL_PES_BOTH,  1},
    '{13'h0011, 1, -1,  PL_COLLIDE,   -1},
    '{13'h1FFF, 0, 183, PL_RAND,      1}   // adaptation fills the packet
  };

  initial begin
    logic [7:0] bad;
    stream_if.valid = 1'b0;
    stream_if.data_byte = 8'h00;
    rec_if.ready = 1'b0;
    parser_reset();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    write_reg(tspp_pkg::CFG_PACKET_LIMIT, 16'hFFFF);
    write_reg(tspp_pkg::CFG_PES_LIMIT, 16'hFFFF);
    // Wait for the counter memory to clear, then hold the receiver off so the
    // parser backs up behind the program table records.
    while (!stream_if.ready) @(posedge clk);
    hold_req++;
    foreach (plan[i]) begin
      typed_hdr.push_back(plan[i].hdr_count);
      add_packet(plan[i].pid, plan[i].pusi, plan[i].afl, plan[i].body);
    end
    drain();

    // From here on a PID gets a PES record only while its PES count is zero.
    write_reg(tspp_pkg::CFG_PES_LIMIT, 16'hFFF1);
    write_reg(tspp_pkg::CFG_PACKET_LIMIT, 16'd5000);
    add_random_packet();
    drain();

    // End on a broken sync byte: one error record, then the parser stops.
    bad = 8'($urandom);
    if (bad == tspp_pkg::SYNC_BYTE) bad = ~bad;
    tx_q.push_back(bad);
    drain();
    repeat (40) @(posedge clk);

    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: transport_stream_packet_parser.f
design/tspp_pkg.sv
design/tspp_if.sv
design/tspp_pidmem.sv
design/tspp_outq.sv
design/tspp_core.sv
design/transport_stream_packet_parser.sv
bench/tb.sv
